// File: rtl/biou_pkg.sv
// Package with shared types and constants for the box overlap ratio block.
package biou_pkg;
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int RATIO_BITS = FRAC_BITS + 1;
    localparam int EDGE_BITS  = COORD_BITS + 1;
    localparam int AREA_BITS  = 2 * COORD_BITS;
    localparam int DEN_BITS   = AREA_BITS + 1;
    localparam int QUO_BITS   = FRAC_BITS + 1;

    localparam logic [1:0] CMD_AREA = 2'd0;
    localparam logic [1:0] CMD_HORZ = 2'd1;
    localparam logic [1:0] CMD_VERT = 2'd2;

    typedef struct packed {
        logic [1:0]            cmd;
        logic [COORD_BITS-1:0] a_x_offset;
        logic [COORD_BITS-1:0] a_y_offset;
        logic [COORD_BITS-1:0] a_width;
        logic [COORD_BITS-1:0] a_height;
        logic [COORD_BITS-1:0] b_x_offset;
        logic [COORD_BITS-1:0] b_y_offset;
        logic [COORD_BITS-1:0] b_width;
        logic [COORD_BITS-1:0] b_height;
    } t_in;

    typedef struct packed {
        logic [RATIO_BITS-1:0] ratio;
        logic                  overlapping;
    } t_out;

    // Restoring divider lane, travels with each item down the divide pipe.
    typedef struct packed {
        logic                  vld;
        logic                  hit;
        logic                  go;
        logic [DEN_BITS-1:0]   rem;
        logic [DEN_BITS-1:0]   den;
        logic [QUO_BITS-1:0]   quo;
    } t_div;
endpackage

// File: rtl/biou_divpipe.sv
// Pipelined restoring fraction divider, one quotient bit per stage.
module biou_divpipe (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  biou_pkg::t_div  i_lane,
    output biou_pkg::t_div  o_lane
);
    import biou_pkg::*;

    localparam int NSTG = QUO_BITS;

    t_div r_stg [NSTG];
    t_div n_stg [NSTG];

    function automatic t_div div_step(input t_div l, input logic first);
        t_div o;
        logic [DEN_BITS:0] sh;
        o = l;
        sh = first ? {1'b0, l.rem} : {l.rem, 1'b0};
        if (sh >= {1'b0, l.den}) begin
            sh = sh - {1'b0, l.den};
            o.quo = {l.quo[QUO_BITS-2:0], 1'b1};
        end else begin
            o.quo = {l.quo[QUO_BITS-2:0], 1'b0};
        end
        o.rem = sh[DEN_BITS-1:0];
        return o;
    endfunction

    always_comb begin
        n_stg[0] = div_step(i_lane, 1'b1);
        for (int i = 1; i < NSTG; i++) begin
            n_stg[i] = div_step(r_stg[i-1], 1'b0);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NSTG; i++) begin
            if (!i_rst_n) begin
                r_stg[i].vld <= 1'b0;
            end else if (i_adv) begin
                r_stg[i] <= n_stg[i];
            end
        end
    end

    assign o_lane = r_stg[NSTG-1];
endmodule

// File: rtl/box_iou_ratio_top.sv
// Top level of the box overlap ratio block.
// This block takes one pair of rectangles per cycle while not stalled and returns
// their overlap ratio (area, horizontal or vertical intersection over union) as an
// unsigned Q1.16 fraction, one result per item, in order. The pipeline is 3 front
// stages (edges and overlap lengths, products, denominator) plus 17 divider
// stages (one quotient bit each) and an output register, 21 registers in all.
// The whole pipe advances when the output register is empty or being taken, so
// a stall holds every item in place and full throughput of one item per cycle is
// kept whenever the sink takes.
module box_iou_ratio_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  biou_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output biou_pkg::t_out  o_data
);
    import biou_pkg::*;

    logic adv;
    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    // Stage 1: edges and overlap lengths.
    logic                  r1_vld, r1_hit;
    logic [1:0]            r1_cmd;
    logic [COORD_BITS-1:0] r1_ox, r1_oy, r1_aw, r1_ah, r1_bw, r1_bh;
    logic [EDGE_BITS-1:0]  lo_x, lo_y, hi_x, hi_y, ae_x, be_x, ae_y, be_y;

    always_comb begin
        ae_x = {1'b0, i_data.a_x_offset} + {1'b0, i_data.a_width};
        be_x = {1'b0, i_data.b_x_offset} + {1'b0, i_data.b_width};
        ae_y = {1'b0, i_data.a_y_offset} + {1'b0, i_data.a_height};
        be_y = {1'b0, i_data.b_y_offset} + {1'b0, i_data.b_height};
        lo_x = (i_data.a_x_offset > i_data.b_x_offset) ? {1'b0, i_data.a_x_offset}
                                                       : {1'b0, i_data.b_x_offset};
        lo_y = (i_data.a_y_offset > i_data.b_y_offset) ? {1'b0, i_data.a_y_offset}
                                                       : {1'b0, i_data.b_y_offset};
        hi_x = (ae_x < be_x) ? ae_x : be_x;
        hi_y = (ae_y < be_y) ? ae_y : be_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (adv) begin
            r1_vld <= i_valid;
        end
        if (adv) begin
            logic [EDGE_BITS-1:0] dx, dy;
            dx = hi_x - lo_x;
            dy = hi_y - lo_y;
            r1_hit <= (hi_x >= lo_x) && (hi_y >= lo_y);
            r1_cmd <= i_data.cmd;
            // Overlap never exceeds either width, so it fits the coordinate width.
            r1_ox  <= dx[COORD_BITS-1:0];
            r1_oy  <= dy[COORD_BITS-1:0];
            r1_aw  <= i_data.a_width;
            r1_ah  <= i_data.a_height;
            r1_bw  <= i_data.b_width;
            r1_bh  <= i_data.b_height;
        end
    end

    // Stage 2: select operands and, for the area command, form the three products.
    logic                 r2_vld, r2_hit, r2_ok;
    logic [AREA_BITS-1:0] r2_int, r2_s1, r2_s2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (adv) begin
            r2_vld <= r1_vld;
        end
        if (adv) begin
            r2_hit <= r1_hit;
            r2_ok  <= 1'b1;
            case (r1_cmd)
                CMD_AREA: begin
                    r2_int <= AREA_BITS'(r1_ox) * AREA_BITS'(r1_oy);
                    r2_s1  <= AREA_BITS'(r1_aw) * AREA_BITS'(r1_ah);
                    r2_s2  <= AREA_BITS'(r1_bw) * AREA_BITS'(r1_bh);
                end
                CMD_HORZ: begin
                    r2_int <= AREA_BITS'(r1_ox);
                    r2_s1  <= AREA_BITS'(r1_aw);
                    r2_s2  <= AREA_BITS'(r1_bw);
                end
                CMD_VERT: begin
                    r2_int <= AREA_BITS'(r1_oy);
                    r2_s1  <= AREA_BITS'(r1_ah);
                    r2_s2  <= AREA_BITS'(r1_bh);
                end
                default: begin
                    r2_int <= '0;
                    r2_s1  <= '0;
                    r2_s2  <= '0;
                    r2_ok  <= 1'b0;
                end
            endcase
        end
    end

    // Stage 3: union denominator and the divide-or-zero decision.
    t_div                lane_in, lane_out;
    logic [DEN_BITS:0]   den_w;

    always_comb begin
        den_w = {2'b0, r2_s1} + {2'b0, r2_s2} - {2'b0, r2_int};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            lane_in.vld <= 1'b0;
        end else if (adv) begin
            lane_in.vld <= r2_vld;
        end
        if (adv) begin
            lane_in.hit <= r2_hit;
            // Zero union, unused selector or a miss all give a zero ratio.
            lane_in.go  <= r2_hit && r2_ok && (den_w != '0);
            lane_in.rem <= {1'b0, r2_int};
            lane_in.den <= den_w[DEN_BITS-1:0];
            lane_in.quo <= '0;
        end
    end

    biou_divpipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_lane  (lane_in),
        .o_lane  (lane_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (adv) begin
            o_valid <= lane_out.vld;
        end
        if (adv) begin
            o_data.ratio       <= lane_out.go ? lane_out.quo : '0;
            o_data.overlapping <= lane_out.hit;
        end
    end
endmodule
